/* hw/rtl/xtsaes_pkg.sv */
// ----------------------------------------------------------------------------
// XTS-AES-128 shared definitions
// Pipeline item type, AES tables and the byte-level round functions used by
// the key cells and the round cells.
// ----------------------------------------------------------------------------
package xtsaes_pkg;

  localparam int unsigned BLOCKS_PER_SECTOR = 1024;
  localparam int unsigned IDX_W = (BLOCKS_PER_SECTOR > 1) ? $clog2(BLOCKS_PER_SECTOR) : 1;
  localparam int unsigned KEY_STAGES   = 10;
  localparam int unsigned ROUND_STAGES = 10;

  localparam logic [7:0] RCON_FIRST = 8'h01;
  localparam logic [7:0] RCON_LAST  = 8'h36;
  localparam logic [7:0] GF8_POLY   = 8'h1b;
  localparam logic [127:0] GF128_POLY = 128'h87;

  // One item moving down the chain: a data block or a tweak computation.
  typedef struct packed {
    logic         valid;
    logic         twk;     // tweak computation, no output produced
    logic         dir;     // 0 encrypt, 1 decrypt
    logic         last;    // last block of the sector
    logic [127:0] tweak;
    logic [127:0] state;
    logic [127:0] key;
    logic [7:0]   rcon;
  } xts_item_t;

  typedef logic [7:0] sbox_tab_t [256];

  localparam sbox_tab_t SBOX = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // The inverse table is derived from the forward one during elaboration.
  function automatic sbox_tab_t inv_table();
    sbox_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[SBOX[i]] = 8'(i);
    end
    return t;
  endfunction

  localparam sbox_tab_t INV_SBOX = inv_table();

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? GF8_POLY : 8'h00);
  endfunction

  // Inverse of xtime, steps the round constant backward.
  function automatic logic [7:0] inv_xtime(input logic [7:0] a);
    logic [7:0] b;
    b = a[0] ? (a ^ GF8_POLY) : a;
    return {a[0], b[7:1]};
  endfunction

  function automatic logic [31:0] key_g(input logic [31:0] w, input logic [7:0] rcon);
    return {SBOX[w[7:0]], SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]] ^ rcon};
  endfunction

  function automatic logic [127:0] key_fwd(input logic [127:0] k, input logic [7:0] rcon);
    logic [31:0] n0, n1, n2, n3;
    n0 = k[31:0] ^ key_g(k[127:96], rcon);
    n1 = k[63:32] ^ n0;
    n2 = k[95:64] ^ n1;
    n3 = k[127:96] ^ n2;
    return {n3, n2, n1, n0};
  endfunction

  function automatic logic [127:0] key_bwd(input logic [127:0] k, input logic [7:0] rcon);
    logic [31:0] p0, p1, p2, p3;
    p3 = k[127:96] ^ k[95:64];
    p2 = k[95:64] ^ k[63:32];
    p1 = k[63:32] ^ k[31:0];
    p0 = k[31:0] ^ key_g(p3, rcon);
    return {p3, p2, p1, p0};
  endfunction

  // SubBytes and ShiftRows, then MixColumns unless it is the final round.
  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic final_rnd);
    logic [127:0] t;
    logic [127:0] m;
    logic [7:0]   a0, a1, a2, a3;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[8*(r+4*c) +: 8] = SBOX[s[8*(r+4*((c+r)%4)) +: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[8*(4*c) +: 8];
      a1 = t[8*(4*c+1) +: 8];
      a2 = t[8*(4*c+2) +: 8];
      a3 = t[8*(4*c+3) +: 8];
      m[8*(4*c) +: 8]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      m[8*(4*c+1) +: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      m[8*(4*c+2) +: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      m[8*(4*c+3) +: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    return final_rnd ? t : m;
  endfunction

  function automatic logic [127:0] dec_sub_shift(input logic [127:0] s);
    logic [127:0] t;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[8*(r+4*c) +: 8] = INV_SBOX[s[8*(r+4*((c+4-r)%4)) +: 8]];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [127:0] m;
    logic [7:0]   a   [4];
    logic [7:0]   x9  [4];
    logic [7:0]   x11 [4];
    logic [7:0]   x13 [4];
    logic [7:0]   x14 [4];
    logic [7:0]   x2, x4, x8;
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        a[j]   = s[8*(4*c+j) +: 8];
        x2     = xtime(a[j]);
        x4     = xtime(x2);
        x8     = xtime(x4);
        x9[j]  = x8 ^ a[j];
        x11[j] = x8 ^ x2 ^ a[j];
        x13[j] = x8 ^ x4 ^ a[j];
        x14[j] = x8 ^ x4 ^ x2;
      end
      m[8*(4*c) +: 8]   = x14[0] ^ x11[1] ^ x13[2] ^ x9[3];
      m[8*(4*c+1) +: 8] = x9[0] ^ x14[1] ^ x11[2] ^ x13[3];
      m[8*(4*c+2) +: 8] = x13[0] ^ x9[1] ^ x14[2] ^ x11[3];
      m[8*(4*c+3) +: 8] = x11[0] ^ x13[1] ^ x9[2] ^ x14[3];
    end
    return m;
  endfunction

  // Multiply the tweak by alpha, little-endian byte order.
  function automatic logic [127:0] mul_alpha(input logic [127:0] t);
    return {t[126:0], 1'b0} ^ (t[127] ? GF128_POLY : 128'h0);
  endfunction

endpackage

/* hw/rtl/xtsaes_key_cell.sv */
// ----------------------------------------------------------------------------
// XTS-AES key cell
// One step of the forward key schedule. Decrypt items advance their key so
// that the last round key is ready when they reach the round cells.
// ----------------------------------------------------------------------------
module xtsaes_key_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  xtsaes_pkg::xts_item_t d,
  output xtsaes_pkg::xts_item_t q
);

  xtsaes_pkg::xts_item_t q_next;

  always_comb begin
    q_next = d;
    if (d.dir) begin
      q_next.key  = xtsaes_pkg::key_fwd(d.key, d.rcon);
      q_next.rcon = xtsaes_pkg::xtime(d.rcon);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (adv) begin
      q <= q_next;
    end
  end

endmodule

/* hw/rtl/xtsaes_round_cell.sv */
// ----------------------------------------------------------------------------
// XTS-AES round cell
// One AES round, forward or inverse, with the round key derived on the fly
// from the key the item carries.
// ----------------------------------------------------------------------------
module xtsaes_round_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  xtsaes_pkg::xts_item_t d,
  output xtsaes_pkg::xts_item_t q
);

  xtsaes_pkg::xts_item_t q_next;
  logic [127:0]          enc_key;
  logic [127:0]          dec_key;
  logic [127:0]          dec_state;
  logic                  enc_final;
  logic                  dec_final;

  always_comb begin
    enc_key   = xtsaes_pkg::key_fwd(d.key, d.rcon);
    dec_key   = xtsaes_pkg::key_bwd(d.key, d.rcon);
    // The round constant in use tells which round this is.
    enc_final = (d.rcon == xtsaes_pkg::RCON_LAST);
    dec_final = (d.rcon == xtsaes_pkg::RCON_FIRST);
    dec_state = xtsaes_pkg::dec_sub_shift(d.state) ^ dec_key;
    q_next    = d;
    if (d.dir) begin
      q_next.state = dec_final ? dec_state : xtsaes_pkg::inv_mix(dec_state);
      q_next.key   = dec_key;
      q_next.rcon  = xtsaes_pkg::inv_xtime(d.rcon);
    end else begin
      q_next.state = xtsaes_pkg::enc_round(d.state, enc_final) ^ enc_key;
      q_next.key   = enc_key;
      q_next.rcon  = xtsaes_pkg::xtime(d.rcon);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (adv) begin
      q <= q_next;
    end
  end

endmodule

/* hw/rtl/xts_aes128_sector_cipher.sv */
// ----------------------------------------------------------------------------
// XTS-AES-128 sector cipher
// Encrypts or decrypts sectors of 128-bit blocks under a data key and a
// tweak key, one block per transfer.
// ----------------------------------------------------------------------------
// Usage: blocks arrive on the s_ channel and results leave on the m_ channel
// in the same order, one result per block; m_tlast marks a sector's last
// block. The first block of a sector carries the direction in s_tuser and
// the sector number in s_tdata; later blocks of the sector ignore both.
// Keys are written through cfg_wr_en, cfg_index and cfg_data while idle.
// At a sector's first block the tweak is encrypted by sending it down the
// same chain of ten key cells and ten round cells; the first block is held
// off until it returns. After that one block per cycle is taken, and each
// result passes through the key cells, round cells and output register.
// When a result waits with m_tready low the whole chain holds, and s_tready
// drops with it.
// Reset empties the chain and starts at a sector boundary.
// ----------------------------------------------------------------------------
module xts_aes128_sector_cipher (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [191:0] s_tdata,   // sector_number, data_low, data_high
  input  logic         s_tuser,   // cmd
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // out_low, out_high
  output logic         m_tlast,   // sector_end
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  typedef enum logic [1:0] {ST_RUN, ST_WAIT, ST_READY} seq_t;

  localparam logic [1:0] REG_DKEY_LO = 2'd0;
  localparam logic [1:0] REG_DKEY_HI = 2'd1;
  localparam logic [1:0] REG_TKEY_LO = 2'd2;
  localparam logic [1:0] REG_TKEY_HI = 2'd3;

  seq_t                              state;
  logic [63:0]                       data_key_low, data_key_high;
  logic [63:0]                       tweak_key_low, tweak_key_high;
  logic [127:0]                      tweak_value;
  logic [xtsaes_pkg::IDX_W-1:0]      block_index;
  logic                              direction;
  logic                              adv;
  logic                              launch;
  logic                              accept;
  logic                              first_blk;
  logic                              last_blk;
  logic                              tweak_back;
  logic [63:0]                       sn_swapped;
  xtsaes_pkg::xts_item_t             entry;
  xtsaes_pkg::xts_item_t             key_q   [xtsaes_pkg::KEY_STAGES];
  xtsaes_pkg::xts_item_t             round_d;
  xtsaes_pkg::xts_item_t             round_q [xtsaes_pkg::ROUND_STAGES];
  xtsaes_pkg::xts_item_t             tail;

  assign adv        = !m_tvalid || m_tready;
  assign first_blk  = (block_index == '0);
  assign last_blk   = (block_index == xtsaes_pkg::IDX_W'(xtsaes_pkg::BLOCKS_PER_SECTOR - 1));
  assign s_tready   = adv && ((state == ST_READY) || ((state == ST_RUN) && !first_blk));
  assign accept     = s_tvalid && s_tready;
  assign launch     = s_tvalid && adv && (state == ST_RUN) && first_blk;
  assign tail       = round_q[xtsaes_pkg::ROUND_STAGES-1];
  assign tweak_back = adv && tail.valid && tail.twk;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      sn_swapped[8*i +: 8] = s_tdata[8*(7-i) +: 8];
    end
    entry = '0;
    if (launch) begin
      // Tweak plaintext: eight zero bytes, then the sector number big-endian.
      entry.valid = 1'b1;
      entry.twk   = 1'b1;
      entry.state = {sn_swapped, 64'h0};
      entry.key   = {tweak_key_high, tweak_key_low};
    end else begin
      entry.valid = accept;
      entry.dir   = first_blk ? s_tuser : direction;
      entry.last  = last_blk;
      entry.tweak = tweak_value;
      entry.state = s_tdata[191:64] ^ tweak_value;
      entry.key   = {data_key_high, data_key_low};
    end
    entry.rcon = xtsaes_pkg::RCON_FIRST;
  end

  xtsaes_key_cell u_key0 (.clk(clk), .rst(rst), .adv(adv), .d(entry), .q(key_q[0]));

  for (genvar g = 1; g < xtsaes_pkg::KEY_STAGES; g++) begin : g_key
    xtsaes_key_cell u_key (.clk(clk), .rst(rst), .adv(adv), .d(key_q[g-1]), .q(key_q[g]));
  end

  // Initial AddRoundKey: the key is the cipher key for encryption and the
  // last round key for decryption.
  always_comb begin
    round_d       = key_q[xtsaes_pkg::KEY_STAGES-1];
    round_d.state = round_d.state ^ round_d.key;
    round_d.rcon  = round_d.dir ? xtsaes_pkg::RCON_LAST : xtsaes_pkg::RCON_FIRST;
  end

  xtsaes_round_cell u_rnd0 (.clk(clk), .rst(rst), .adv(adv), .d(round_d), .q(round_q[0]));

  for (genvar g = 1; g < xtsaes_pkg::ROUND_STAGES; g++) begin : g_rnd
    xtsaes_round_cell u_rnd (.clk(clk), .rst(rst), .adv(adv), .d(round_q[g-1]),
                             .q(round_q[g]));
  end

  always_ff @(posedge clk) begin
    if (tweak_back) begin
      tweak_value <= tail.state;
    end else if (accept) begin
      tweak_value <= xtsaes_pkg::mul_alpha(tweak_value);
    end
    if (adv) begin
      m_tdata <= tail.state ^ tail.tweak;
      m_tlast <= tail.last;
    end
    if (rst) begin
      data_key_low   <= '0;
      data_key_high  <= '0;
      tweak_key_low  <= '0;
      tweak_key_high <= '0;
      state          <= ST_RUN;
      block_index    <= '0;
      direction      <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_DKEY_LO: data_key_low   <= cfg_data;
          REG_DKEY_HI: data_key_high  <= cfg_data;
          REG_TKEY_LO: tweak_key_low  <= cfg_data;
          REG_TKEY_HI: tweak_key_high <= cfg_data;
          default:     data_key_low   <= data_key_low;
        endcase
      end
      if (adv) begin
        m_tvalid <= tail.valid && !tail.twk;
      end
      if (accept) begin
        block_index <= last_blk ? '0 : block_index + 1'b1;
        if (first_blk) begin
          direction <= s_tuser;
        end
      end
      case (state)
        ST_RUN:   if (launch) state <= ST_WAIT;
        ST_WAIT:  if (tweak_back) state <= ST_READY;
        ST_READY: if (accept) state <= ST_RUN;
        default:  state <= ST_RUN;
      endcase
    end
  end

  a_no_accept_while_waiting: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WAIT) |-> !s_tready)
    else $error("block taken while the tweak is in flight");

  a_tweak_only_when_waiting: assert property (@(posedge clk) disable iff (rst)
    (tail.valid && tail.twk) |-> (state == ST_WAIT))
    else $error("tweak result arrived outside the wait state");

  a_first_block_has_tweak: assert property (@(posedge clk) disable iff (rst)
    (accept && first_blk) |-> (state == ST_READY))
    else $error("first block of a sector taken without a fresh tweak");

  a_launch_waits: assert property (@(posedge clk) disable iff (rst)
    launch |=> (state == ST_WAIT))
    else $error("tweak launch did not enter the wait state");

endmodule

/* bench/tb_xts_aes128_sector_cipher.sv */
// ----------------------------------------------------------------------------
// Testbench for the XTS-AES-128 sector cipher
// Streams a full sector and part of the next under changing keys and
// flow control, and checks every result against a behavioral model kept in
// this bench, with AES and the tweak update computed at block level.
// ----------------------------------------------------------------------------
module tb_xts_aes128_sector_cipher;

  localparam int unsigned SECTOR_BLOCKS = xtsaes_pkg::BLOCKS_PER_SECTOR;
  localparam int unsigned DRAIN_CYCLES  = 40;
  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned HOLD_CYCLES   = 300;

  typedef enum logic [1:0] {
    REG_DATA_KEY_LO  = 2'd0,
    REG_DATA_KEY_HI  = 2'd1,
    REG_TWEAK_KEY_LO = 2'd2,
    REG_TWEAK_KEY_HI = 2'd3
  } key_reg_e;

  typedef struct packed {
    logic        cmd;
    logic [63:0] sn;
    logic [63:0] lo;
    logic [63:0] hi;
  } block_in_t;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
    logic        last;
  } block_out_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [191:0] s_tdata = '0;   // sector_number, data_low, data_high
  logic         s_tuser = 1'b0; // cmd
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;        // out_low, out_high
  logic         m_tlast;        // sector_end
  logic         cfg_wr_en = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [63:0]  cfg_data = '0;

  xts_aes128_sector_cipher u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Model state: keys, running tweak, position in the sector, direction.
  logic [127:0] data_key = '0;
  logic [127:0] tw_key = '0;
  logic [127:0] run_tweak = '0;
  int unsigned  sector_pos = 0;
  logic         sector_dir = 1'b0;
  logic [7:0]   fwd_sub [256];
  logic [7:0]   inv_sub [256];

  block_out_t   pending_blocks [$];
  int unsigned  errors = 0;
  int unsigned  cycles = 0;
  int unsigned  issued = 0;
  int unsigned  idle_pct = 0;
  int unsigned  stall_pct = 0;
  bit           hold_req = 1'b0;
  int unsigned  hold_left = 0;

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return r;
  endfunction

  // S-box from the multiplicative inverse followed by the affine map.
  task automatic build_sbox();
    logic [7:0] v, s;
    for (int x = 0; x < 256; x++) begin
      v = '0;
      for (int y = 1; y < 256; y++) begin
        if (gf_mul(8'(x), 8'(y)) == 8'h01) v = 8'(y);
      end
      s = v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]} ^ {v[3:0], v[7:4]}
          ^ 8'h63;
      fwd_sub[x] = s;
      inv_sub[s] = 8'(x);
    end
  endtask

  function automatic logic [1407:0] round_keys(logic [127:0] k);
    logic [1407:0] rk;
    logic [7:0]    t0, t1, t2, t3, x, rc;
    rk = '0;
    rk[127:0] = k;
    rc = 8'h01;
    for (int i = 4; i < 44; i++) begin
      t0 = rk[32*(i-1) +: 8];
      t1 = rk[32*(i-1)+8 +: 8];
      t2 = rk[32*(i-1)+16 +: 8];
      t3 = rk[32*(i-1)+24 +: 8];
      if (i % 4 == 0) begin
        x  = t0;
        t0 = fwd_sub[t1] ^ rc;
        t1 = fwd_sub[t2];
        t2 = fwd_sub[t3];
        t3 = fwd_sub[x];
        rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
      end
      rk[32*i +: 32] = rk[32*(i-4) +: 32] ^ {t3, t2, t1, t0};
    end
    return rk;
  endfunction

  function automatic logic [127:0] cipher_fwd(logic [127:0] s, logic [1407:0] rk);
    logic [127:0] t;
    logic [7:0]   a0, a1, a2, a3, x0, x1, x2, x3;
    s ^= rk[127:0];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          t[8*(r+4*c) +: 8] = fwd_sub[s[8*(r+4*((c+r)%4)) +: 8]];
        end
      end
      if (rnd < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[32*c +: 8]; a1 = t[32*c+8 +: 8]; a2 = t[32*c+16 +: 8]; a3 = t[32*c+24 +: 8];
          x0 = gf_mul(a0, 8'h02); x1 = gf_mul(a1, 8'h02);
          x2 = gf_mul(a2, 8'h02); x3 = gf_mul(a3, 8'h02);
          s[32*c +: 8]    = x0 ^ x1 ^ a1 ^ a2 ^ a3;
          s[32*c+8 +: 8]  = a0 ^ x1 ^ x2 ^ a2 ^ a3;
          s[32*c+16 +: 8] = a0 ^ a1 ^ x2 ^ x3 ^ a3;
          s[32*c+24 +: 8] = x0 ^ a0 ^ a1 ^ a2 ^ x3;
        end
      end else begin
        s = t;
      end
      s ^= rk[128*rnd +: 128];
    end
    return s;
  endfunction

  function automatic logic [127:0] cipher_inv(logic [127:0] s, logic [1407:0] rk);
    logic [127:0] t;
    logic [7:0]   a0, a1, a2, a3;
    s ^= rk[1280 +: 128];
    for (int rnd = 10; rnd >= 1; rnd--) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          t[8*(r+4*c) +: 8] = inv_sub[s[8*(r+4*((c+4-r)%4)) +: 8]];
        end
      end
      s = t ^ rk[128*(rnd-1) +: 128];
      if (rnd > 1) begin
        for (int c = 0; c < 4; c++) begin
          a0 = s[32*c +: 8]; a1 = s[32*c+8 +: 8]; a2 = s[32*c+16 +: 8]; a3 = s[32*c+24 +: 8];
          s[32*c +: 8]    = gf_mul(a0, 8'd14) ^ gf_mul(a1, 8'd11) ^ gf_mul(a2, 8'd13)
                            ^ gf_mul(a3, 8'd9);
          s[32*c+8 +: 8]  = gf_mul(a0, 8'd9) ^ gf_mul(a1, 8'd14) ^ gf_mul(a2, 8'd11)
                            ^ gf_mul(a3, 8'd13);
          s[32*c+16 +: 8] = gf_mul(a0, 8'd13) ^ gf_mul(a1, 8'd9) ^ gf_mul(a2, 8'd14)
                            ^ gf_mul(a3, 8'd11);
          s[32*c+24 +: 8] = gf_mul(a0, 8'd11) ^ gf_mul(a1, 8'd13) ^ gf_mul(a2, 8'd9)
                            ^ gf_mul(a3, 8'd14);
        end
      end
    end
    return s;
  endfunction

  // Works out the result of one accepted block and advances the sector state.
  task automatic predict_block(block_in_t b);
    logic [127:0] x;
    block_out_t   e;
    if (sector_pos == 0) begin
      sector_dir = b.cmd;
      run_tweak = '0;
      for (int i = 0; i < 8; i++) run_tweak[64+8*i +: 8] = b.sn[56-8*i +: 8];
      run_tweak = cipher_fwd(run_tweak, round_keys(tw_key));
    end
    x = {b.hi, b.lo} ^ run_tweak;
    x = sector_dir ? cipher_inv(x, round_keys(data_key)) : cipher_fwd(x, round_keys(data_key));
    x ^= run_tweak;
    e.lo = x[63:0];
    e.hi = x[127:64];
    e.last = (sector_pos == SECTOR_BLOCKS - 1);
    pending_blocks.push_back(e);
    run_tweak = {run_tweak[126:0], 1'b0} ^ (run_tweak[127] ? 128'h87 : 128'h0);
    sector_pos = e.last ? 0 : sector_pos + 1;
  endtask

  task automatic write_keys(logic [63:0] dlo, logic [63:0] dhi, logic [63:0] tlo,
                            logic [63:0] thi);
    logic [63:0] vals [4];
    vals = '{dlo, dhi, tlo, thi};
    for (int i = 0; i < 4; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      case (key_reg_e'(i))
        REG_DATA_KEY_LO:  data_key[63:0]    = vals[i];
        REG_DATA_KEY_HI:  data_key[127:64]  = vals[i];
        REG_TWEAK_KEY_LO: tw_key[63:0]      = vals[i];
        REG_TWEAK_KEY_HI: tw_key[127:64]    = vals[i];
        default: ;
      endcase
    end
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_block(block_in_t b);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {b.hi, b.lo, b.sn};
    s_tuser  <= b.cmd;
    do @(posedge clk); while (!s_tready);
    predict_block(b);
    issued++;
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Sector starts walk through both directions and a sector number of zero;
  // mid-sector command and sector number are noise.
  task automatic send_random(int unsigned count);
    block_in_t b;
    for (int n = 0; n < count; n++) begin
      b.cmd = 1'($urandom);
      b.sn = {$urandom, $urandom};
      if (issued % SECTOR_BLOCKS == 0) begin
        case (issued / SECTOR_BLOCKS)
          1: begin b.cmd = 1'b1; b.sn = '0; end
          2: b.cmd = 1'b1;
          3: b.cmd = 1'b0;
          default: ;
        endcase
      end
      b.lo = rand_word();
      b.hi = rand_word();
      send_block(b);
    end
    s_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Opening blocks of the first sector: extremes of the data words, with
  // command and sector number changing on blocks where they must be ignored.
  block_in_t directed_rows [16] = '{
    '{1'b0, 64'hffff_ffff_ffff_ffff, 64'h0, 64'h0},
    '{1'b1, 64'h0, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff},
    '{1'b1, 64'h0, 64'h0, 64'hffff_ffff_ffff_ffff},
    '{1'b0, 64'h1234_5678_9abc_def0, 64'hffff_ffff_ffff_ffff, 64'h0},
    '{1'b1, 64'hffff_ffff_ffff_ffff, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa},
    '{1'b0, 64'h0, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555},
    '{1'b0, 64'h1, 64'h1, 64'h0},
    '{1'b1, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h0},
    '{1'b0, 64'h0, 64'h0, 64'h1},
    '{1'b0, 64'h0, 64'h0, 64'h8000_0000_0000_0000},
    '{1'b1, 64'h0, 64'h0, 64'h0},
    '{1'b0, 64'h0, 64'h0, 64'h0},
    '{1'b0, 64'h0, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff},
    '{1'b1, 64'h0, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff},
    '{1'b0, 64'h0, 64'h0, 64'h0},
    '{1'b0, 64'h0, 64'hdead_beef_0000_0001, 64'h0000_0001_dead_beef}
  };

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    block_out_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_blocks.size() == 0) begin
        $error("result with no expectation: out_low %h out_high %h", m_tdata[63:0],
               m_tdata[127:64]);
        errors++;
      end else begin
        e = pending_blocks.pop_front();
        if (m_tdata[63:0] !== e.lo) begin
          $error("out_low expected %h actual %h", e.lo, m_tdata[63:0]);
          errors++;
        end
        if (m_tdata[127:64] !== e.hi) begin
          $error("out_high expected %h actual %h", e.hi, m_tdata[127:64]);
          errors++;
        end
        if (m_tlast !== e.last) begin
          $error("sector_end expected %b actual %b", e.last, m_tlast);
          errors++;
        end
      end
    end
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    build_sbox();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Keys still at their reset value of zero.
    foreach (directed_rows[i]) send_block(directed_rows[i]);
    s_tvalid <= 1'b0;
    drain();

    // Key changes below land in the middle of a sector, where the latched
    // tweak must survive.
    write_keys('1, '1, '1, '1);
    send_random(300);
    drain();

    write_keys({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
               {$urandom, $urandom});
    idle_pct = 83;
    send_random(300);
    drain();

    write_keys({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
               {$urandom, $urandom});
    idle_pct = 0;
    stall_pct = 83;
    send_random(300);
    drain();

    write_keys('0, '0, '0, '0);
    idle_pct = 16;
    stall_pct = 16;
    send_random(250);
    drain();

    // Long receiver hold-off while the sender keeps pushing, so the chain
    // fills and the input stalls.
    write_keys({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
               {$urandom, $urandom});
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b1;
    send_random(184);
    drain();

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* xts_aes128_sector_cipher.f */
hw/rtl/xtsaes_pkg.sv
hw/rtl/xtsaes_key_cell.sv
hw/rtl/xtsaes_round_cell.sv
hw/rtl/xts_aes128_sector_cipher.sv
bench/tb_xts_aes128_sector_cipher.sv
